@@ rtl/core/elst_pkg.sv @@
// ----------------------------------------------------------------------------
// elst_pkg
// Shared types, widths and codes for the L2 learning switch table.
// ----------------------------------------------------------------------------
package elst_pkg;

    // table and port sizing
    localparam int TABLE_ENTRIES = 4;
    localparam int MAX_PORTS     = 32;

    // fixed field widths
    localparam int MAC_W      = 48;
    localparam int PORT_W     = 5;
    localparam int MASK_W     = 32;
    localparam int TIME_W     = 32;
    localparam int PCOUNT_W   = 6;
    localparam int ACTION_W   = 2;

    // configuration port
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_PORT_MASK    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PORTS_IN_USE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIFETIME     = 2'd2;

    // register reset values
    localparam logic [MASK_W-1:0]   PORT_MASK_RST    = '0;
    localparam logic [PCOUNT_W-1:0] PORTS_IN_USE_RST = PCOUNT_W'(MAX_PORTS);
    localparam logic [TIME_W-1:0]   LIFETIME_RST     = TIME_W'(15000);

    // forwarding decision
    typedef enum logic [ACTION_W-1:0] {
        ACT_UNICAST   = 2'd0,
        ACT_FLOOD     = 2'd1,
        ACT_DROP_SAME = 2'd2,
        ACT_DROP_BAD  = 2'd3
    } t_action;

    // one frame header
    typedef struct packed {
        logic [MAC_W-1:0]  source_mac;
        logic [MAC_W-1:0]  dest_mac;
        logic [PORT_W-1:0] ingress_port;
        logic [TIME_W-1:0] now_ms;
    } t_frame;

    // one forwarding result
    typedef struct packed {
        t_action           action;
        logic [MASK_W-1:0] egress_mask;
        logic              source_learned;
        logic              table_full;
    } t_result;

    // configuration seen by the table
    typedef struct packed {
        logic [MASK_W-1:0] usable;
        logic [TIME_W-1:0] lifetime;
    } t_cfg;

    // lowest set bit of a slot vector, as a one-hot vector
    function automatic logic [TABLE_ENTRIES-1:0] lowest_set(
        input logic [TABLE_ENTRIES-1:0] v
    );
        return v & (~v + TABLE_ENTRIES'(1));
    endfunction

endpackage

@@ rtl/core/elst_if.sv @@
// ----------------------------------------------------------------------------
// elst_in_if / elst_out_if
// Valid/ready channels for frame headers and forwarding results.
// ----------------------------------------------------------------------------

// frame header channel
interface elst_in_if import elst_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MAC_W-1:0]  source_mac;
    logic [MAC_W-1:0]  dest_mac;
    logic [PORT_W-1:0] ingress_port;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, source_mac, dest_mac, ingress_port, now_ms,
                    input ready);
    modport sink   (input valid, source_mac, dest_mac, ingress_port, now_ms,
                    output ready);
endinterface

// forwarding result channel
interface elst_out_if import elst_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [MASK_W-1:0]   egress_mask;
    logic                source_learned;
    logic                table_full;

    modport source (output valid, action, egress_mask, source_learned, table_full,
                    input ready);
    modport sink   (input valid, action, egress_mask, source_learned, table_full,
                    output ready);
endinterface

@@ rtl/core/ethernet_learning_switch_table.sv @@
// ----------------------------------------------------------------------------
// ethernet_learning_switch_table
// L2 learning switch table: learns source MACs, forwards on destination MAC.
// Result path: input register, then result register. One header per cycle
// while results are taken; the table is read and updated in the same cycle.
// A stalled result holds the input register, which then holds the header port.
// Reset: synchronous, active low; all table entries invalid, registers to
// their defaults (no ports connected, 32 ports in use, 15000 ms lifetime).
// ----------------------------------------------------------------------------
module ethernet_learning_switch_table import elst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    elst_in_if.sink           i_frame,
    elst_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_frame  r_item;
    t_result r_res;
    t_result res;
    logic    r_in_valid, n_in_valid;
    logic    r_out_valid, n_out_valid;
    logic    advance, fire, in_accept;

    elst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    elst_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .i_fire  (fire),
        .o_res   (res)
    );

    // handshake: result register frees when taken, input stage moves with it
    assign advance         = !r_out_valid || o_result.ready;
    assign fire            = r_in_valid && advance;
    assign i_frame.ready   = !r_in_valid || advance;
    assign in_accept       = i_frame.valid && i_frame.ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (in_accept) n_in_valid = 1'b1;
        else if (advance) n_in_valid = 1'b0;
        if (fire) n_out_valid = 1'b1;
        else if (o_result.ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.source_mac   <= i_frame.source_mac;
            r_item.dest_mac     <= i_frame.dest_mac;
            r_item.ingress_port <= i_frame.ingress_port;
            r_item.now_ms       <= i_frame.now_ms;
        end
        if (fire) r_res <= res;
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.action         = r_res.action;
    assign o_result.egress_mask    = r_res.egress_mask;
    assign o_result.source_learned = r_res.source_learned;
    assign o_result.table_full     = r_res.table_full;

endmodule

@@ rtl/core/elst_cfg.sv @@
// ----------------------------------------------------------------------------
// elst_cfg
// APB register file: connected mask, ports in use, entry lifetime.
// ----------------------------------------------------------------------------
module elst_cfg import elst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [MASK_W-1:0]    r_port_mask;
    logic [PCOUNT_W-1:0]  r_ports_in_use;
    logic [TIME_W-1:0]    r_lifetime;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [PCOUNT_W-1:0]  n_ports;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_mask    <= PORT_MASK_RST;
            r_ports_in_use <= PORTS_IN_USE_RST;
            r_lifetime     <= LIFETIME_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PORT_MASK:    r_port_mask    <= pwdata[MASK_W-1:0];
                REG_PORTS_IN_USE: r_ports_in_use <= pwdata[PCOUNT_W-1:0];
                REG_LIFETIME:     r_lifetime     <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_PORT_MASK:    prdata = r_port_mask;
            REG_PORTS_IN_USE: prdata = {{(DATA_W-PCOUNT_W){1'b0}}, r_ports_in_use};
            REG_LIFETIME:     prdata = r_lifetime;
            default:          prdata = '0;
        endcase
    end

    // usable ports: connected and below the clamped port count
    always_comb begin
        n_ports = r_ports_in_use;
        if (n_ports == '0) n_ports = PCOUNT_W'(1);
        if (n_ports > PCOUNT_W'(MAX_PORTS)) n_ports = PCOUNT_W'(MAX_PORTS);
        o_cfg.usable = '0;
        for (int p = 0; p < MAX_PORTS; p++) begin
            o_cfg.usable[p] = r_port_mask[p] & (PCOUNT_W'(p) < n_ports);
        end
        o_cfg.lifetime = r_lifetime;
    end

endmodule

@@ rtl/core/elst_table.sv @@
// ----------------------------------------------------------------------------
// elst_table
// MAC table with parallel compare: learns the source, then forwards on dest.
// ----------------------------------------------------------------------------
module elst_table import elst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_frame  i_item,
    input  logic    i_fire,
    output t_result o_res
);

    // table storage; only valid entries are ever looked at
    logic                r_valid [TABLE_ENTRIES];
    logic [MAC_W-1:0]    r_mac   [TABLE_ENTRIES];
    logic [PORT_W-1:0]   r_port  [TABLE_ENTRIES];
    logic [TIME_W-1:0]   r_stamp [TABLE_ENTRIES];
    logic                n_valid [TABLE_ENTRIES];

    logic [MASK_W-1:0]        ingress_bit;
    logic                     ingress_ok;
    logic [TABLE_ENTRIES-1:0] src_hit, dst_hit, free_slot, expired;
    logic [TABLE_ENTRIES-1:0] hit_oh, free_oh, exp_oh, wr_oh;
    logic [TABLE_ENTRIES-1:0] dst_match, dst_oh;
    logic                     learn_ok;
    logic                     d_any, d_exp;
    logic [PORT_W-1:0]        d_port;
    logic                     invalidate;

    assign ingress_bit = MASK_W'(1) << i_item.ingress_port;
    assign ingress_ok  = i_cfg.usable[i_item.ingress_port];

    // per-entry compares and ages
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            src_hit[i]   = r_valid[i] && (r_mac[i] == i_item.source_mac);
            dst_hit[i]   = r_valid[i] && (r_mac[i] == i_item.dest_mac);
            free_slot[i] = !r_valid[i];
            expired[i]   = TIME_W'(i_item.now_ms - r_stamp[i]) > i_cfg.lifetime;
        end
    end

    // learn slot: existing entry, else lowest free, else lowest expired
    assign hit_oh   = lowest_set(src_hit);
    assign free_oh  = lowest_set(free_slot);
    assign exp_oh   = lowest_set(expired);
    assign learn_ok = |src_hit || |free_slot || |expired;
    assign wr_oh    = !ingress_ok ? '0 :
                      |src_hit    ? hit_oh :
                      |free_slot  ? free_oh : exp_oh;

    // dest lookup on the table as it stands after learning
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            dst_match[i] = wr_oh[i] ? (i_item.source_mac == i_item.dest_mac)
                                    : dst_hit[i];
        end
    end
    assign dst_oh = lowest_set(dst_match);
    assign d_any  = |dst_match;

    // fields of the matching entry; a freshly written entry has age zero
    always_comb begin
        d_exp  = 1'b0;
        d_port = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (dst_oh[i]) begin
                d_exp  = expired[i] && !wr_oh[i];
                d_port = wr_oh[i] ? i_item.ingress_port : r_port[i];
            end
        end
    end

    assign invalidate = i_fire && ingress_ok && d_any && d_exp;

    // forwarding decision
    always_comb begin
        o_res.action         = ACT_DROP_BAD;
        o_res.egress_mask    = '0;
        o_res.source_learned = 1'b0;
        o_res.table_full     = 1'b0;
        if (ingress_ok) begin
            o_res.source_learned = learn_ok;
            o_res.table_full     = !learn_ok;
            if (!d_any || d_exp || !i_cfg.usable[d_port]) begin
                o_res.action      = ACT_FLOOD;
                o_res.egress_mask = i_cfg.usable & ~ingress_bit;
            end else if (d_port == i_item.ingress_port) begin
                o_res.action = ACT_DROP_SAME;
            end else begin
                o_res.action      = ACT_UNICAST;
                o_res.egress_mask = MASK_W'(1) << d_port;
            end
        end
    end

    // valid bits: set on learn, cleared when a stale dest entry is hit
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            if (i_fire && wr_oh[i]) n_valid[i] = 1'b1;
            if (invalidate && dst_oh[i]) n_valid[i] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else begin
                r_valid[i] <= n_valid[i];
            end
        end
    end

    // entry contents
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i_fire && wr_oh[i]) begin
                r_mac[i]   <= i_item.source_mac;
                r_port[i]  <= i_item.ingress_port;
                r_stamp[i] <= i_item.now_ms;
            end
        end
    end

endmodule

@@ rtl/core/elst_check.sv @@
// ----------------------------------------------------------------------------
// elst_check
// Port-level checks on the result channel of the switch table.
// ----------------------------------------------------------------------------
module elst_check import elst_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [ACTION_W-1:0] i_action,
    input logic [MASK_W-1:0]   i_egress_mask,
    input logic                i_source_learned,
    input logic                i_table_full
);

    // a stalled item stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // a stalled item keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_action) && $stable(i_egress_mask)
            && $stable(i_source_learned) && $stable(i_table_full))
        else $error("result payload changed while stalled");

    // bad ingress leaves everything clear
    a_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_action == ACT_DROP_BAD |->
            i_egress_mask == '0 && !i_source_learned && !i_table_full)
        else $error("bad ingress result carries flags or ports");

    // a usable ingress either learns or reports a full table
    a_learn_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_action != ACT_DROP_BAD |-> i_source_learned != i_table_full)
        else $error("learned and full flags inconsistent");

    // unicast goes to exactly one port, same-port drop to none
    a_unicast_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == ACT_UNICAST || i_action == ACT_DROP_SAME) |->
            (i_action == ACT_UNICAST) ? $onehot(i_egress_mask) : (i_egress_mask == '0))
        else $error("egress mask does not match action");

endmodule

bind ethernet_learning_switch_table elst_check u_elst_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_action         (o_result.action),
    .i_egress_mask    (o_result.egress_mask),
    .i_source_learned (o_result.source_learned),
    .i_table_full     (o_result.table_full)
);

@@ bench/ethernet_learning_switch_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ethernet_learning_switch_table_tb
// Self-checking bench for the L2 learning switch table. Frame headers go in
// through a queued driver and every accepted header is run through a local
// model of the learn/lookup table. Each forwarding result is compared field
// by field with the oldest prediction. Register settings change between
// phases while the block is idle. Random traffic uses a small MAC pool so
// that learning, aging, table full and unicast hits all happen often.
// ----------------------------------------------------------------------------
module ethernet_learning_switch_table_tb;
    import elst_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 75;
    localparam int POOL_SIZE    = 6;

    logic i_clk;
    logic i_rst_n;

    // config port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    elst_in_if  frame_if ();
    elst_out_if result_if ();

    ethernet_learning_switch_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // model copy of the registers and the MAC table
    logic [MASK_W-1:0]   cfg_port_mask;
    logic [PCOUNT_W-1:0] cfg_port_count;
    logic [TIME_W-1:0]   cfg_lifetime;
    logic                tbl_valid [TABLE_ENTRIES];
    logic [MAC_W-1:0]    tbl_mac   [TABLE_ENTRIES];
    logic [PORT_W-1:0]   tbl_port  [TABLE_ENTRIES];
    logic [TIME_W-1:0]   tbl_stamp [TABLE_ENTRIES];

    // headers waiting to be driven, forwarding results waiting to arrive
    t_frame  header_backlog [$];
    t_result forward_backlog [$];

    int   headers_queued;
    int   headers_taken;
    int   results_seen;
    int   fail_count;
    int   cycle_count;
    int   settings_count;
    int   action_count [4];
    int   full_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hdr_accepted;
    logic [TIME_W-1:0] wall_ms;

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------

    // connected ports among those in use; count 0 acts as 1, above 32 as 32
    function automatic logic [MASK_W-1:0] usable_ports();
        int              n;
        logic [MASK_W:0] span;
        n = cfg_port_count;
        if (n < 1) n = 1;
        if (n > MAX_PORTS) n = MAX_PORTS;
        span = ((MASK_W+1)'(1) << n) - (MASK_W+1)'(1);
        return cfg_port_mask & span[MASK_W-1:0];
    endfunction

    // age is taken modulo 2^32
    function automatic logic entry_stale(int i, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        age = now - tbl_stamp[i];
        return age > cfg_lifetime;
    endfunction

    function automatic int find_entry(logic [MAC_W-1:0] mac);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        end
        return -1;
    endfunction

    // learn the source, then decide where the frame goes
    function automatic t_result forward_decision(t_frame f);
        t_result           r;
        logic [MASK_W-1:0] usable;
        logic [MASK_W-1:0] in_bit;
        int                slot;
        usable           = usable_ports();
        in_bit           = MASK_W'(1) << f.ingress_port;
        r.action         = ACT_DROP_BAD;
        r.egress_mask    = '0;
        r.source_learned = 1'b0;
        r.table_full     = 1'b0;
        if ((usable & in_bit) == '0) return r;

        // a known source is refreshed even when stale
        slot = find_entry(f.source_mac);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && entry_stale(i, f.now_ms)) slot = i;
        end
        if (slot >= 0) begin
            tbl_valid[slot]  = 1'b1;
            tbl_mac[slot]    = f.source_mac;
            tbl_port[slot]   = f.ingress_port;
            tbl_stamp[slot]  = f.now_ms;
            r.source_learned = 1'b1;
        end else begin
            r.table_full = 1'b1;
        end

        // stale destination is dropped from the table; dead port is a miss
        slot = find_entry(f.dest_mac);
        if (slot >= 0 && entry_stale(slot, f.now_ms)) begin
            tbl_valid[slot] = 1'b0;
            slot = -1;
        end
        if (slot >= 0 && !usable[tbl_port[slot]]) slot = -1;

        if (slot < 0) begin
            r.action      = ACT_FLOOD;
            r.egress_mask = usable & ~in_bit;
        end else if (tbl_port[slot] == f.ingress_port) begin
            r.action = ACT_DROP_SAME;
        end else begin
            r.action      = ACT_UNICAST;
            r.egress_mask = MASK_W'(1) << tbl_port[slot];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, forward_backlog.size());
            $display("** ethernet_learning_switch_table: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: headers from the backlog, random gaps and back-pressure
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive
        logic   next_valid;
        t_frame next_hdr;
        next_valid = frame_if.valid;
        next_hdr   = '{frame_if.source_mac, frame_if.dest_mac,
                       frame_if.ingress_port, frame_if.now_ms};
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (frame_if.valid && hdr_accepted) next_valid = 1'b0;
            if (!next_valid && header_backlog.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                next_hdr   = header_backlog.pop_front();
                next_valid = 1'b1;
            end
        end
        frame_if.valid        <= next_valid;
        frame_if.source_mac   <= next_hdr.source_mac;
        frame_if.dest_mac     <= next_hdr.dest_mac;
        frame_if.ingress_port <= next_hdr.ingress_port;
        frame_if.now_ms       <= next_hdr.now_ms;
        result_if.ready       <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: check results, predict accepted headers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_result exp;
        t_frame  hdr;
        hdr_accepted = i_rst_n && frame_if.valid && frame_if.ready;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            results_seen++;
            if (forward_backlog.size() == 0) begin
                $error("result item with no prediction pending");
                fail_count++;
            end else begin
                exp = forward_backlog.pop_front();
                if (result_if.action !== exp.action) begin
                    $error("action: expected %0d, got %0d", exp.action, result_if.action);
                    fail_count++;
                end
                if (result_if.egress_mask !== exp.egress_mask) begin
                    $error("egress_mask: expected %h, got %h",
                           exp.egress_mask, result_if.egress_mask);
                    fail_count++;
                end
                if (result_if.source_learned !== exp.source_learned) begin
                    $error("source_learned: expected %0b, got %0b",
                           exp.source_learned, result_if.source_learned);
                    fail_count++;
                end
                if (result_if.table_full !== exp.table_full) begin
                    $error("table_full: expected %0b, got %0b",
                           exp.table_full, result_if.table_full);
                    fail_count++;
                end
            end
        end
        if (hdr_accepted) begin
            hdr = '{frame_if.source_mac, frame_if.dest_mac,
                    frame_if.ingress_port, frame_if.now_ms};
            exp = forward_decision(hdr);
            action_count[exp.action]++;
            if (exp.table_full) full_count++;
            forward_backlog.push_back(exp);
            headers_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    // random port among the set bits of m (any port when m is empty)
    function automatic logic [PORT_W-1:0] random_port_in(logic [MASK_W-1:0] m);
        logic [PORT_W-1:0] p;
        p = PORT_W'($urandom_range(0, MAX_PORTS - 1));
        if (m == '0) return p;
        while (!m[p]) p = p + PORT_W'(1);
        return p;
    endfunction

    task automatic queue_frame(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                               logic [PORT_W-1:0] port, logic [TIME_W-1:0] now);
        header_backlog.push_back('{src, dst, port, now});
        headers_queued++;
    endtask

    // every header taken and every result back, then let the pipe empty
    task automatic drain();
        while (headers_taken != headers_queued || forward_backlog.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PORT_MASK:    cfg_port_mask  = value;
            REG_PORTS_IN_USE: cfg_port_count = value[PCOUNT_W-1:0];
            REG_LIFETIME:     cfg_lifetime   = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_cfg(logic [MASK_W-1:0] mask, logic [PCOUNT_W-1:0] count,
                             logic [TIME_W-1:0] life);
        drain();
        reg_write(REG_PORT_MASK, mask);
        reg_write(REG_PORTS_IN_USE, DATA_W'(count));
        reg_write(REG_LIFETIME, life);
        settings_count++;
    endtask

    // small MAC pool, each with a home port, so entries get hit and age out
    task automatic run_random_phase(int n);
        logic [MAC_W-1:0]  pool [POOL_SIZE];
        logic [PORT_W-1:0] home [POOL_SIZE];
        logic [MASK_W-1:0] usable;
        logic [TIME_W-1:0] step;
        logic [MAC_W-1:0]  src;
        logic [MAC_W-1:0]  dst;
        logic [PORT_W-1:0] port;
        int                j;
        usable = usable_ports();
        if (cfg_lifetime == '0) step = 2;
        else if (cfg_lifetime > 6000) step = 2000;
        else step = cfg_lifetime / 3 + 1;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool[k] = rand_mac();
            home[k] = random_port_in(usable);
        end
        repeat (n) begin
            j   = $urandom_range(0, POOL_SIZE - 1);
            src = ($urandom_range(0, 99) < 85) ? pool[j] : rand_mac();
            dst = ($urandom_range(0, 99) < 85) ?
                  pool[$urandom_range(0, POOL_SIZE - 1)] : rand_mac();
            if ($urandom_range(0, 99) < 75) port = home[j];
            else if ($urandom_range(0, 99) < 50) port = random_port_in(usable);
            else port = PORT_W'($urandom_range(0, MAX_PORTS - 1));
            // mostly a forward-running clock, with rare jumps anywhere
            if ($urandom_range(0, 99) < 3) wall_ms = $urandom();
            else wall_ms = wall_ms + $urandom_range(0, step);
            queue_frame(src, dst, port, wall_ms);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        logic [MAC_W-1:0] mac_a;
        logic [MAC_W-1:0] mac_b;
        logic [MAC_W-1:0] mac_c;
        logic [MAC_W-1:0] mac_d;
        logic [MAC_W-1:0] mac_e;
        logic [MAC_W-1:0] mac_f;
        logic [MAC_W-1:0] mac_g;
        logic [MAC_W-1:0] mac_h;

        // every input known from time zero
        i_rst_n                = 1'b0;
        frame_if.valid         = 1'b0;
        frame_if.source_mac    = '0;
        frame_if.dest_mac      = '0;
        frame_if.ingress_port  = '0;
        frame_if.now_ms        = '0;
        result_if.ready        = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        hdr_accepted           = 1'b0;
        headers_queued         = 0;
        headers_taken          = 0;
        results_seen           = 0;
        fail_count             = 0;
        cycle_count            = 0;
        settings_count         = 0;
        full_count             = 0;
        wall_ms                = '0;
        action_count           = '{0, 0, 0, 0};
        send_idle_pct          = 27;
        recv_idle_pct          = 68;
        cfg_port_mask          = PORT_MASK_RST;
        cfg_port_count         = PORTS_IN_USE_RST;
        cfg_lifetime           = LIFETIME_RST;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_mac[i]   = '0;
            tbl_port[i]  = '0;
            tbl_stamp[i] = '0;
        end

        mac_a = 48'h0000_0000_0000;
        mac_b = 48'hFFFF_FFFF_FFFF;
        mac_c = 48'h0200_0000_0001;
        mac_d = 48'h5555_5555_5555;
        mac_e = 48'hAAAA_AAAA_AAAA;
        mac_f = 48'h1234_5678_9ABC;
        mac_g = 48'h8000_0000_0000;
        mac_h = 48'h0000_0000_0001;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset registers: no port connected, so everything is a bad ingress
        queue_frame(mac_b, mac_a, 5'd0, 32'd0);
        queue_frame(mac_a, mac_b, 5'd31, 32'hFFFF_FFFF);

        // all ports, short lifetime: learn, unicast, same-port drop, table full
        apply_cfg(32'hFFFF_FFFF, 6'd32, 32'd100);
        queue_frame(mac_a, mac_b, 5'd0, 32'd1000);
        queue_frame(mac_b, mac_a, 5'd31, 32'd1000);
        queue_frame(mac_c, mac_a, 5'd0, 32'd1000);
        queue_frame(mac_d, mac_c, 5'd5, 32'd1000);
        queue_frame(mac_e, mac_d, 5'd7, 32'd1050);
        // stale source refreshed; stale destination invalidated and flooded
        queue_frame(mac_a, mac_b, 5'd3, 32'd1200);
        // freed slot reused, then a stale slot taken for a new source
        queue_frame(mac_e, mac_e, 5'd7, 32'd1200);
        queue_frame(mac_f, mac_c, 5'd9, 32'd1200);

        // port 7 unplugged, entries never age; clock wraps around
        apply_cfg(32'hFFFF_FF7F, 6'd32, 32'hFFFF_FFFF);
        queue_frame(mac_a, mac_e, 5'd3, 32'd5);
        queue_frame(mac_f, mac_a, 5'd9, 32'h8000_0000);
        queue_frame(mac_g, mac_a, 5'd7, 32'h8000_0001);

        // zero ports in use acts as one port; zero lifetime
        apply_cfg(32'hFFFF_FFFF, 6'd0, 32'd0);
        queue_frame(mac_g, mac_a, 5'd0, 32'd100);
        queue_frame(mac_h, mac_g, 5'd1, 32'd100);

        // count above 32 clamps to 32; default lifetime
        apply_cfg(32'hFFFF_FFFF, 6'd63, 32'd15000);
        queue_frame(mac_h, mac_g, 5'd31, 32'd100);
        queue_frame(mac_g, mac_h, 5'd31, 32'd100);
        queue_frame(mac_d, mac_h, 5'd16, 32'd20000);

        // random traffic under several settings
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: apply_cfg(32'hFFFF_FFFF, 6'd32, 32'd500);
                1: apply_cfg($urandom(), PCOUNT_W'($urandom_range(1, 32)),
                             $urandom_range(50, 3000));
                2: apply_cfg($urandom() | 32'h1, PCOUNT_W'($urandom_range(0, 4)), 32'd0);
                3: apply_cfg($urandom(), PCOUNT_W'($urandom_range(33, 63)),
                             32'hFFFF_FFFF);
                4: apply_cfg(32'hFFFF_FFFF, 6'd32, 32'd15000);
                default: apply_cfg($urandom(), PCOUNT_W'($urandom_range(0, 63)),
                                   $urandom_range(100, 1000));
            endcase
            if (k < 2) begin
                send_idle_pct = 27;
                recv_idle_pct = 68;
            end else if (k < 4) begin
                send_idle_pct = 68;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (forward_backlog.size() != 0) begin
            $error("%0d predicted results never arrived", forward_backlog.size());
            fail_count++;
        end

        $display("%0d headers, %0d results over %0d register settings",
                 headers_taken, results_seen, settings_count);
        $display("unicast %0d, flood %0d, same-port drop %0d, bad ingress %0d, full %0d",
                 action_count[ACT_UNICAST], action_count[ACT_FLOOD],
                 action_count[ACT_DROP_SAME], action_count[ACT_DROP_BAD], full_count);
        if (fail_count == 0) begin
            $display("** ethernet_learning_switch_table: PASSED **");
        end else begin
            $display("** ethernet_learning_switch_table: FAILED **");
        end
        $finish;
    end

endmodule
